>>> rtl/mck_pkg.sv
// Shared types, constants and the character code table for the Morse keyer.
// Used by every module of the block; depends on nothing else.
package mck_pkg;

  localparam int CharW   = 7;   // ASCII code width
  localparam int CodeW   = 7;   // sentinel Morse code width
  localparam int CountW  = 3;   // elements in one character
  localparam int TickW   = 5;   // tick counter and duration registers
  localparam int StatusW = 2;
  localparam int CfgIdxW = 3;
  localparam int TableN  = 36;
  localparam int TableIdxW = 6;

  // Offer status codes
  localparam logic [StatusW-1:0] ST_NONE     = 2'd0;
  localparam logic [StatusW-1:0] ST_ACCEPTED = 2'd1;
  localparam logic [StatusW-1:0] ST_BUSY     = 2'd2;
  localparam logic [StatusW-1:0] ST_UNSUPP   = 2'd3;

  // Input command codes
  localparam logic CMD_OFFER = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_DOT    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DASH   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_EGAP   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LGAP   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WORD   = 3'd4;

  // Register reset values
  localparam logic [TickW-1:0] DOT_RESET  = 5'd2;
  localparam logic [TickW-1:0] DASH_RESET = 5'd6;
  localparam logic [TickW-1:0] EGAP_RESET = 5'd2;
  localparam logic [TickW-1:0] LGAP_RESET = 5'd6;
  localparam logic [TickW-1:0] WORD_RESET = 5'd14;

  // ASCII anchors
  localparam logic [CharW-1:0] ASC_SPACE = 7'd32;
  localparam logic [CharW-1:0] ASC_ZERO  = 7'd48;
  localparam logic [CharW-1:0] ASC_NINE  = 7'd57;
  localparam logic [CharW-1:0] ASC_A     = 7'd65;
  localparam logic [CharW-1:0] ASC_Z     = 7'd90;
  localparam logic [CharW-1:0] ASC_LETTER_BASE = 7'd55; // 'A' minus ten
  localparam logic [CharW-1:0] ASC_COLON = 7'd58;
  localparam logic [CharW-1:0] ASC_COMMA = 7'd44;
  localparam logic [CharW-1:0] ASC_BANG  = 7'd33;
  localparam logic [CharW-1:0] ASC_DASH  = 7'd45;
  localparam logic [CharW-1:0] ASC_AT    = 7'd64;
  localparam logic [CharW-1:0] ASC_DOT   = 7'd46;
  localparam logic [CharW-1:0] ASC_QUERY = 7'd63;

  // Punctuation sentinel codes
  localparam logic [CodeW-1:0] CODE_COLON = 7'd71;
  localparam logic [CodeW-1:0] CODE_COMMA = 7'd76;
  localparam logic [CodeW-1:0] CODE_BANG  = 7'd84;
  localparam logic [CodeW-1:0] CODE_DASH  = 7'd94;
  localparam logic [CodeW-1:0] CODE_AT    = 7'd101;
  localparam logic [CodeW-1:0] CODE_DOT   = 7'd106;
  localparam logic [CodeW-1:0] CODE_QUERY = 7'd115;

  // Sentinel codes for '0'..'9' then 'A'..'Z'; 1 = dot, 0 = dash
  localparam logic [CodeW-1:0] CODE_TABLE [TableN] = '{
    7'd32, 7'd48, 7'd56, 7'd60, 7'd62, 7'd63, 7'd47, 7'd39, 7'd35, 7'd33,
    7'd6,  7'd23, 7'd21, 7'd11, 7'd3,  7'd29, 7'd9,  7'd31, 7'd7,  7'd24,
    7'd10, 7'd27, 7'd4,  7'd5,  7'd8,  7'd25, 7'd18, 7'd13, 7'd15, 7'd2,
    7'd14, 7'd30, 7'd12, 7'd22, 7'd20, 7'd19
  };

  // Duration registers
  typedef struct packed {
    logic [TickW-1:0] dot_ticks;
    logic [TickW-1:0] dash_ticks;
    logic [TickW-1:0] element_gap_ticks;
    logic [TickW-1:0] letter_gap_ticks;
    logic [TickW-1:0] word_gap_ticks;
  } cfg_t;

  // Lookup result
  typedef struct packed {
    logic              supported;
    logic              is_space;
    logic [CodeW-1:0]  code;
    logic [CountW-1:0] elements;
  } lookup_t;

  // One result item
  typedef struct packed {
    logic               key_on;
    logic               char_done;
    logic               busy_res;
    logic [StatusW-1:0] offer_status;
  } result_t;

endpackage

>>> rtl/morse_code_keyer_top.sv
// Morse code keyer top level: input register, duration registers, result register.
// Depends on mck_pkg and mck_keyer.
//
//  Channel   Signals                           Carries
//  s_        s_tvalid s_tready s_tdata s_tuser  command, offered character
//  m_        m_tvalid m_tready m_tdata          one result per input item
//  cfg_      cfg_valid cfg_ready cfg_index      duration register writes
//            cfg_data
//
// Each item passes through the input register, then through the keyer into the result
// register. One item per cycle sustained while the m_ side does not stall.
// A stalled m_ side holds the result register; the input register then holds and
// s_tready drops only when both are full. Reset clears all valid flags, keying
// state and restores the default durations. Configuration writes always complete.
module morse_code_keyer_top (
  input  logic       clk,
  input  logic       rst,
  // Input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [6:0] char_code, [7] zero
  input  logic       s_tuser,    // [0] command
  // Result stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [0] key_on, [1] char_done, [2] busy_res,
                                 // [4:3] offer_status, [7:5] zero
  // Configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mck_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [mck_pkg::TickW-1:0]     cfg_data
);

  logic                      in_valid;
  logic                      in_command;
  logic [mck_pkg::CharW-1:0] in_char;
  logic                      advance;
  mck_pkg::cfg_t             cfg;
  mck_pkg::result_t          result;
  mck_pkg::result_t          out_result;

  // Handshake: the keyer stage moves when the result register can take it
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_command <= s_tuser;
      in_char    <= s_tdata[mck_pkg::CharW-1:0];
    end
  end

  // Duration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dot_ticks         <= mck_pkg::DOT_RESET;
      cfg.dash_ticks        <= mck_pkg::DASH_RESET;
      cfg.element_gap_ticks <= mck_pkg::EGAP_RESET;
      cfg.letter_gap_ticks  <= mck_pkg::LGAP_RESET;
      cfg.word_gap_ticks    <= mck_pkg::WORD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mck_pkg::REG_DOT:  cfg.dot_ticks         <= cfg_data;
        mck_pkg::REG_DASH: cfg.dash_ticks        <= cfg_data;
        mck_pkg::REG_EGAP: cfg.element_gap_ticks <= cfg_data;
        mck_pkg::REG_LGAP: cfg.letter_gap_ticks  <= cfg_data;
        mck_pkg::REG_WORD: cfg.word_gap_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  mck_keyer u_keyer (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .command   (in_command),
    .char_code (in_char),
    .cfg       (cfg),
    .result    (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tdata = {3'b000, out_result.offer_status, out_result.busy_res,
                    out_result.char_done, out_result.key_on};

endmodule

>>> rtl/mck_lookup.sv
// Character decoder: ASCII code to sentinel Morse code and element count.
// Depends on mck_pkg for the code table and constants.
module mck_lookup (
  input  logic [mck_pkg::CharW-1:0] char_code,
  output mck_pkg::lookup_t          info
);

  logic [mck_pkg::TableIdxW-1:0] digit_idx;
  logic [mck_pkg::TableIdxW-1:0] letter_idx;
  logic [mck_pkg::CodeW-1:0]     code;
  logic                          supported;
  logic                          is_space;
  logic [mck_pkg::CountW-1:0]    elements;

  assign digit_idx  = mck_pkg::TableIdxW'(char_code - mck_pkg::ASC_ZERO);
  assign letter_idx = mck_pkg::TableIdxW'(char_code - mck_pkg::ASC_LETTER_BASE);

  // Map the character onto its code
  always_comb begin
    supported = 1'b1;
    is_space  = 1'b0;
    code      = '0;
    if (char_code == mck_pkg::ASC_SPACE) begin
      is_space = 1'b1;
    end else if (char_code == mck_pkg::ASC_COLON) begin
      code = mck_pkg::CODE_COLON;
    end else if (char_code == mck_pkg::ASC_COMMA) begin
      code = mck_pkg::CODE_COMMA;
    end else if (char_code == mck_pkg::ASC_BANG) begin
      code = mck_pkg::CODE_BANG;
    end else if (char_code == mck_pkg::ASC_DASH) begin
      code = mck_pkg::CODE_DASH;
    end else if (char_code == mck_pkg::ASC_AT) begin
      code = mck_pkg::CODE_AT;
    end else if (char_code == mck_pkg::ASC_DOT) begin
      code = mck_pkg::CODE_DOT;
    end else if (char_code == mck_pkg::ASC_QUERY) begin
      code = mck_pkg::CODE_QUERY;
    end else if (char_code inside {[mck_pkg::ASC_ZERO:mck_pkg::ASC_NINE]}) begin
      code = mck_pkg::CODE_TABLE[digit_idx];
    end else if (char_code inside {[mck_pkg::ASC_A:mck_pkg::ASC_Z]}) begin
      code = mck_pkg::CODE_TABLE[letter_idx];
    end else begin
      supported = 1'b0;
    end
  end

  // Element count is the sentinel's bit position
  always_comb begin
    elements = '0;
    for (int i = 1; i < mck_pkg::CodeW; i++) begin
      if (code[i]) elements = mck_pkg::CountW'(i);
    end
  end

  assign info = {supported, is_space, code, elements};

endmodule

>>> rtl/mck_keyer.sv
// Keying state machine: phase, element and tick state, and the next result.
// Depends on mck_pkg and mck_lookup.
module mck_keyer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,   // item in the input register is consumed
  input  logic                      command,
  input  logic [mck_pkg::CharW-1:0] char_code,
  input  mck_pkg::cfg_t             cfg,
  output mck_pkg::result_t          result
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_MARK = 3'd1,
    PH_EGAP = 3'd2,
    PH_WORD = 3'd3,
    PH_LGAP = 3'd4
  } phase_t;

  phase_t                      phase, phase_next;
  logic [mck_pkg::CodeW-1:0]   code_shift, code_shift_next;
  logic [mck_pkg::CountW-1:0]  elements_left, elements_left_next;
  logic [mck_pkg::TickW-1:0]   tick_count, tick_count_next;

  mck_pkg::lookup_t            info;
  logic [mck_pkg::CountW-1:0]  bit_sel;
  logic                        is_dot;
  logic [mck_pkg::TickW-1:0]   phase_len;
  logic [mck_pkg::TickW-1:0]   tick_inc;
  logic                        phase_end;

  mck_lookup u_lookup (
    .char_code (char_code),
    .info      (info)
  );

  // Current element: bit just below the remaining elements
  assign bit_sel = elements_left - 1'b1;
  assign is_dot  = (bit_sel < mck_pkg::CountW'(mck_pkg::CodeW)) ? code_shift[bit_sel] : 1'b0;

  // Length of the running phase
  always_comb begin
    case (phase)
      PH_MARK: phase_len = is_dot ? cfg.dot_ticks : cfg.dash_ticks;
      PH_EGAP: phase_len = cfg.element_gap_ticks;
      PH_WORD: phase_len = cfg.word_gap_ticks;
      PH_LGAP: phase_len = cfg.letter_gap_ticks;
      default: phase_len = '0;
    endcase
  end

  // Zero length ends after one tick, as does counter wrap
  assign tick_inc  = tick_count + 1'b1;
  assign phase_end = (tick_inc >= phase_len) || (tick_inc == '0);

  // Next state and result for the item at the input register
  always_comb begin
    phase_next         = phase;
    code_shift_next    = code_shift;
    elements_left_next = elements_left;
    tick_count_next    = tick_count;
    result             = '0;

    if (command == mck_pkg::CMD_OFFER) begin
      if (phase != PH_IDLE) begin
        result.offer_status = mck_pkg::ST_BUSY;
      end else if (!info.supported) begin
        result.offer_status = mck_pkg::ST_UNSUPP;
      end else begin
        result.offer_status = mck_pkg::ST_ACCEPTED;
        tick_count_next     = '0;
        code_shift_next     = info.code;
        elements_left_next  = info.elements;
        phase_next          = info.is_space ? PH_WORD : PH_MARK;
      end
    end else begin
      if (phase != PH_IDLE) begin
        tick_count_next = phase_end ? '0 : tick_inc;
      end
      case (phase)
        PH_MARK: begin
          result.key_on = 1'b1;
          if (phase_end) phase_next = PH_EGAP;
        end
        PH_EGAP: begin
          if (phase_end) begin
            elements_left_next = elements_left - 1'b1;
            phase_next = (elements_left == mck_pkg::CountW'(1)) ? PH_LGAP : PH_MARK;
          end
        end
        PH_WORD: begin
          if (phase_end) phase_next = PH_LGAP;
        end
        PH_LGAP: begin
          if (phase_end) begin
            phase_next         = PH_IDLE;
            code_shift_next    = '0;
            elements_left_next = '0;
            result.char_done   = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
    result.busy_res = (phase_next != PH_IDLE);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      code_shift    <= '0;
      elements_left <= '0;
      tick_count    <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      code_shift    <= code_shift_next;
      elements_left <= elements_left_next;
      tick_count    <= tick_count_next;
    end
  end

endmodule
